[rtl/trf_pkg.sv]
// shared types, constants and helpers for the trace record ring
package trf_pkg;

    localparam int CAPACITY    = 256;
    localparam int RECORD_BITS = 32;
    localparam int SLOT_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int WORD_BITS   = 32;

    typedef enum logic [0:0] {
        ACT_WRITE = 1'b0,
        ACT_READ  = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef logic [SLOT_W-1:0]      slot_t;
    typedef logic [RECORD_BITS-1:0] record_t;
    typedef logic [WORD_BITS-1:0]   word_t;

    typedef struct packed {
        action_t action;
        word_t   payload;
    } item_t;

    typedef struct packed {
        status_t status;
        word_t   read_payload;
        word_t   read_seq;
        word_t   drop_count;
    } result_t;

    typedef struct packed {
        logic    wr_en;
        slot_t   wr_addr;
        record_t wr_data;
        logic    rd_en;
        slot_t   rd_addr;
    } ram_req_t;

    typedef struct packed {
        logic    valid;
        logic    hit;
        status_t status;
        word_t   read_seq;
        word_t   drop_count;
    } resp_t;

    function automatic record_t to_record(input word_t w);
        logic [RECORD_BITS+WORD_BITS-1:0] wide;
        wide = {{RECORD_BITS{1'b0}}, w};
        return wide[RECORD_BITS-1:0];
    endfunction

    function automatic word_t from_record(input record_t r);
        logic [RECORD_BITS+WORD_BITS-1:0] wide;
        wide = {{WORD_BITS{1'b0}}, r};
        return wide[WORD_BITS-1:0];
    endfunction

    function automatic slot_t next_slot(input slot_t s);
        logic [SLOT_W:0] inc;
        inc = {1'b0, s} + 1'b1;
        return (inc >= (SLOT_W+1)'(CAPACITY)) ? '0 : inc[SLOT_W-1:0];
    endfunction

endpackage

[rtl/trace_ring_fifo_unit.sv]
// top level of the trace record ring: control, record memory and result output
//
// Trace record ring holding up to 256 records that drops writes when full. One
// word is taken on every clock (busy stays low) and its result appears with done
// in the next cycle, so the rate is one word per cycle, set by the single write
// port and registered read port of the record memory. Results cannot be stalled;
// every word, write or read, gives one result carrying the saturating drop count.
module trace_ring_fifo_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  trf_pkg::item_t    item,
    output logic              done,
    output trf_pkg::result_t  result
);

    trf_pkg::ram_req_t ram_req;
    trf_pkg::resp_t    resp;
    trf_pkg::record_t  rd_data;
    logic              accept;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    trf_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .item    (item),
        .ram_req (ram_req),
        .resp    (resp)
    );

    trf_ram #(
        .WIDTH (trf_pkg::RECORD_BITS),
        .DEPTH (trf_pkg::CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        done                = resp.valid;
        result.status       = resp.status;
        result.read_payload = resp.hit ? trf_pkg::from_record(rd_data) : '0;
        result.read_seq     = resp.read_seq;
        result.drop_count   = resp.drop_count;
    end

endmodule

[rtl/trf_ram.sv]
// generic single write, single read ram with registered read data
module trf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/trf_ctrl.sv]
// cursor, occupancy and drop counter logic with the registered response
module trf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  trf_pkg::item_t   item,
    output trf_pkg::ram_req_t ram_req,
    output trf_pkg::resp_t   resp
);

    trf_pkg::word_t   wr_cur_reg, wr_cur_next;
    trf_pkg::word_t   rd_cur_reg, rd_cur_next;
    trf_pkg::word_t   drop_reg, drop_next;
    trf_pkg::slot_t   wr_slot_reg, wr_slot_next;
    trf_pkg::slot_t   rd_slot_reg, rd_slot_next;
    trf_pkg::resp_t   resp_reg, resp_next;
    trf_pkg::word_t   held;
    logic             full;
    logic             empty;

    always_comb
    begin
        held         = wr_cur_reg - rd_cur_reg;
        full         = held >= trf_pkg::word_t'(trf_pkg::CAPACITY);
        empty        = held == '0;
        wr_cur_next  = wr_cur_reg;
        rd_cur_next  = rd_cur_reg;
        drop_next    = drop_reg;
        wr_slot_next = wr_slot_reg;
        rd_slot_next = rd_slot_reg;
        ram_req.wr_en   = 1'b0;
        ram_req.wr_addr = wr_slot_reg;
        ram_req.wr_data = trf_pkg::to_record(item.payload);
        ram_req.rd_en   = 1'b0;
        ram_req.rd_addr = rd_slot_reg;
        resp_next.valid      = accept;
        resp_next.hit        = 1'b0;
        resp_next.status     = trf_pkg::ST_OK;
        resp_next.read_seq   = '0;
        if (accept)
        begin
            if (item.action == trf_pkg::ACT_WRITE)
            begin
                if (full)
                begin
                    resp_next.status = trf_pkg::ST_FULL;
                    if (drop_reg != '1)
                    begin
                        drop_next = drop_reg + 1'b1;
                    end
                end
                else
                begin
                    ram_req.wr_en = 1'b1;
                    wr_slot_next  = trf_pkg::next_slot(wr_slot_reg);
                    wr_cur_next   = wr_cur_reg + 1'b1;
                end
            end
            else
            begin
                if (empty)
                begin
                    resp_next.status = trf_pkg::ST_EMPTY;
                end
                else
                begin
                    ram_req.rd_en      = 1'b1;
                    resp_next.hit      = 1'b1;
                    resp_next.read_seq = rd_cur_reg;
                    rd_slot_next       = trf_pkg::next_slot(rd_slot_reg);
                    rd_cur_next        = rd_cur_reg + 1'b1;
                end
            end
        end
        resp_next.drop_count = drop_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_cur_reg  <= '0;
            rd_cur_reg  <= '0;
            drop_reg    <= '0;
            wr_slot_reg <= '0;
            rd_slot_reg <= '0;
            resp_reg    <= '0;
        end
        else
        begin
            wr_cur_reg  <= wr_cur_next;
            rd_cur_reg  <= rd_cur_next;
            drop_reg    <= drop_next;
            wr_slot_reg <= wr_slot_next;
            rd_slot_reg <= rd_slot_next;
            resp_reg    <= resp_next;
        end
    end

    assign resp = resp_reg;

endmodule
